[src/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the hash core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising clock edge out of reset
`define ASSERT_ON_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// condition must never be seen at a rising clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_ON_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[src/mash_pkg.sv]
// Shared types, constants and helper functions of the string hash core.
package mash_pkg;

  // field widths
  localparam int unsigned HASH_W       = 32;
  localparam int unsigned KEY_BYTE_W   = 8;
  localparam int unsigned KEY_LEN_W    = 16;
  localparam int unsigned ALG_W        = 4;
  localparam int unsigned BUCKET_CNT_W = 17;
  localparam int unsigned BUCKET_IDX_W = 16;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 17;
  localparam int unsigned S_TDATA_W    = 24;
  localparam int unsigned M_TDATA_W    = 48;

  // bucket count saturates here
  localparam int unsigned MAX_BUCKETS  = 65536;

  // bit-serial remainder: one dividend bit per cycle
  localparam int unsigned DIV_STEPS    = HASH_W;
  localparam int unsigned DIV_CNT_W    = $clog2(DIV_STEPS);

  // hash constants
  localparam logic [HASH_W-1:0] RS_MULT_INIT  = 32'd63689;
  localparam logic [HASH_W-1:0] RS_MULT_STEP  = 32'd378551;
  localparam logic [HASH_W-1:0] JS_INIT       = 32'd1315423911;
  localparam logic [HASH_W-1:0] DJB_INIT      = 32'd5381;
  localparam logic [HASH_W-1:0] BKDR_SEED     = 32'd131;
  localparam logic [HASH_W-1:0] FNV_MULT      = 32'h811C9DC5;
  localparam logic [HASH_W-1:0] AP_INIT       = 32'hAAAAAAAA;
  localparam logic [HASH_W-1:0] PJW_HIGH_MASK = 32'hF0000000;

  localparam logic [BUCKET_CNT_W-1:0] BUCKET_CNT_RESET = 17'd256;

  // algorithm select codes
  typedef enum logic [ALG_W-1:0] {
    ALG_RS   = 4'd0,
    ALG_JS   = 4'd1,
    ALG_PJW  = 4'd2,
    ALG_ELF  = 4'd3,
    ALG_BKDR = 4'd4,
    ALG_SDBM = 4'd5,
    ALG_DJB  = 4'd6,
    ALG_DEK  = 4'd7,
    ALG_BP   = 4'd8,
    ALG_FNV  = 4'd9,
    ALG_AP   = 4'd10
  } alg_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HASH_ALGORITHM = 1'b0,
    CFG_BUCKET_COUNT   = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [1:0] {
    ST_BYTE,
    ST_DIV,
    ST_DONE
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic absorb;
    logic div_start;
    logic div_step;
    logic out_load;
  } dp_cmd_t;

  // start value of the running hash for a given algorithm
  function automatic logic [HASH_W-1:0] start_value(logic [ALG_W-1:0] alg,
                                                    logic [KEY_LEN_W-1:0] len);
    logic [HASH_W-1:0] v;
    unique case (alg)
      ALG_JS:  v = JS_INIT;
      ALG_DJB: v = DJB_INIT;
      ALG_DEK: v = HASH_W'(len);
      ALG_AP:  v = AP_INIT;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/multi_algorithm_string_hash_core.sv]
// Key bytes stream in at one per cycle while the selected hash runs; a byte
// flagged tlast ends the key, after which the input stalls while a bit-serial
// remainder unit reduces the hash by the bucket count and the result register
// is loaded (later if that register is still full). tuser on the input
// restarts the hash; configuration writes are always accepted and
// must only be made while no key is in flight.
module multi_algorithm_string_hash_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input byte stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mash_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // key_byte[7:0], key_length[23:8]
  input  logic                                s_axis_tlast,  // last_byte
  input  logic                                s_axis_tuser,  // first_byte
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mash_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // hash_value[31:0], bucket_index[47:32]
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mash_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mash_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  `include "assert_macros.svh"

  mash_pkg::dp_cmd_t                 cmd;
  logic [mash_pkg::HASH_W-1:0]       hash_value;
  logic [mash_pkg::BUCKET_IDX_W-1:0] bucket_index;

  assign cfg_ready_o = 1'b1;

  // controller
  mash_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  // datapath
  mash_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_byte_i     (s_axis_tdata[mash_pkg::KEY_BYTE_W-1:0]),
    .first_byte_i   (s_axis_tuser),
    .key_length_i   (s_axis_tdata[mash_pkg::S_TDATA_W-1:mash_pkg::KEY_BYTE_W]),
    .hash_value_o   (hash_value),
    .bucket_index_o (bucket_index)
  );

  assign m_axis_tdata = {bucket_index, hash_value};

  // end of key stalls the input while the remainder runs
  `ASSERT_ON_CLK(a_last_stalls_input, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "input still ready after last byte")
  // a new result only appears while byte intake is held off
  `ASSERT_ON_CLK(a_result_while_stalled, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "result loaded while taking bytes")
  // with no result pending, none appears straight after a key end
  `ASSERT_ON_CLK(a_no_early_result, (s_axis_tvalid && s_axis_tready && s_axis_tlast && !m_axis_tvalid) |=> !m_axis_tvalid, "result before remainder done")

endmodule

[src/mash_ctrl.sv]
// Controller state machine: byte intake, remainder sequencing, result hand-off.
module mash_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_last_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output mash_pkg::dp_cmd_t   cmd_o
);

  mash_pkg::state_e                 state_q, state_d;
  logic [mash_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mash_pkg::ST_BYTE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      mash_pkg::ST_BYTE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.absorb = 1'b1;
          if (in_last_i) begin
            cmd_o.div_start = 1'b1;
            cnt_d           = '0;
            state_d         = mash_pkg::ST_DIV;
          end
        end
      end
      mash_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == mash_pkg::DIV_CNT_W'(mash_pkg::DIV_STEPS - 1)) begin
          state_d = mash_pkg::ST_DONE;
        end
      end
      mash_pkg::ST_DONE: begin
        // wait for a free output register
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = mash_pkg::ST_BYTE;
        end
      end
      default: begin
        state_d = mash_pkg::ST_BYTE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[src/mash_dp.sv]
// Datapath: config registers, hash update, bit-serial remainder, result register.
module mash_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mash_pkg::dp_cmd_t                   cmd_i,
  input  logic                                cfg_valid_i,
  input  logic [mash_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mash_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [mash_pkg::KEY_BYTE_W-1:0]     key_byte_i,
  input  logic                                first_byte_i,
  input  logic [mash_pkg::KEY_LEN_W-1:0]      key_length_i,
  output logic [mash_pkg::HASH_W-1:0]         hash_value_o,
  output logic [mash_pkg::BUCKET_IDX_W-1:0]   bucket_index_o
);

  // configuration
  logic [mash_pkg::ALG_W-1:0]        alg_q;
  logic [mash_pkg::BUCKET_CNT_W-1:0] bucket_cnt_q;

  // hash state
  logic [mash_pkg::HASH_W-1:0]       hash_q, hash_d;
  logic [mash_pkg::HASH_W-1:0]       rs_mult_q, rs_mult_d;
  logic                              parity_q, parity_d;

  // divider
  logic [mash_pkg::HASH_W-1:0]       div_num_q;
  logic [mash_pkg::BUCKET_CNT_W-1:0] div_rem_q, div_den_q;
  logic [mash_pkg::BUCKET_CNT_W-1:0] rem_next, eff_cnt;
  logic [mash_pkg::BUCKET_CNT_W:0]   div_shift, div_den_ext, div_sub;

  // output register
  logic [mash_pkg::HASH_W-1:0]       out_hash_q;
  logic [mash_pkg::BUCKET_IDX_W-1:0] out_bucket_q;

  // absorb path
  logic [mash_pkg::HASH_W-1:0]       h0, rs_mult0, c32;
  logic                              parity0;
  logic [mash_pkg::HASH_W-1:0]       mul_a, mul_b, mul_p;
  logic [mash_pkg::HASH_W-1:0]       pjw_g, pjw_t;

  // configuration writes, ready is always high
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alg_q        <= '0;
      bucket_cnt_q <= mash_pkg::BUCKET_CNT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mash_pkg::CFG_HASH_ALGORITHM: alg_q        <= cfg_data_i[mash_pkg::ALG_W-1:0];
        mash_pkg::CFG_BUCKET_COUNT:   bucket_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // restart values on the first byte of a key
  always_comb begin
    c32      = mash_pkg::HASH_W'(key_byte_i);
    h0       = first_byte_i ? mash_pkg::start_value(alg_q, key_length_i) : hash_q;
    rs_mult0 = first_byte_i ? mash_pkg::RS_MULT_INIT : rs_mult_q;
    parity0  = first_byte_i ? 1'b0 : parity_q;
  end

  // 32x32 multiplier shared by the RS, BKDR, FNV and AP steps, low half kept
  always_comb begin
    mul_a = h0;
    mul_b = rs_mult0;
    case (alg_q)
      mash_pkg::ALG_BKDR: mul_b = mash_pkg::BKDR_SEED;
      mash_pkg::ALG_FNV:  mul_b = mash_pkg::FNV_MULT;
      mash_pkg::ALG_AP: begin
        mul_a = c32;
        mul_b = h0 >> 3;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // PJW / ELF fold of the top nibble
  assign pjw_g = (h0 << 4) + c32;
  assign pjw_t = pjw_g & mash_pkg::PJW_HIGH_MASK;

  // per-algorithm byte step
  always_comb begin
    unique case (alg_q) inside
      mash_pkg::ALG_RS:   hash_d = mul_p + c32;
      mash_pkg::ALG_JS:   hash_d = h0 ^ ((h0 << 5) + c32 + (h0 >> 2));
      mash_pkg::ALG_PJW, mash_pkg::ALG_ELF: begin
        if (pjw_t != '0) begin
          hash_d = (pjw_g ^ (pjw_t >> 24)) & ~mash_pkg::PJW_HIGH_MASK;
        end else begin
          hash_d = pjw_g;
        end
      end
      mash_pkg::ALG_BKDR: hash_d = mul_p + c32;
      mash_pkg::ALG_SDBM: hash_d = c32 + (h0 << 6) + (h0 << 16) - h0;
      mash_pkg::ALG_DJB:  hash_d = (h0 << 5) + h0 + c32;
      mash_pkg::ALG_DEK:  hash_d = ((h0 << 5) ^ (h0 >> 27)) ^ c32;
      mash_pkg::ALG_BP:   hash_d = (h0 << 7) ^ c32;
      mash_pkg::ALG_FNV:  hash_d = mul_p ^ c32;
      mash_pkg::ALG_AP: begin
        if (!parity0) begin
          hash_d = h0 ^ ((h0 << 7) ^ mul_p);
        end else begin
          hash_d = h0 ^ ~((h0 << 11) + (c32 ^ (h0 >> 5)));
        end
      end
      default:            hash_d = h0;
    endcase
  end

  // RS multiplier advances by a constant factor each byte
  assign rs_mult_d = rs_mult0 * mash_pkg::RS_MULT_STEP;
  assign parity_d  = ~parity0;

  // hash state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q    <= '0;
      rs_mult_q <= mash_pkg::RS_MULT_INIT;
      parity_q  <= 1'b0;
    end else if (cmd_i.absorb) begin
      hash_q    <= hash_d;
      rs_mult_q <= rs_mult_d;
      parity_q  <= parity_d;
    end
  end

  // effective bucket count: zero reads as one, large values saturate
  always_comb begin
    if (bucket_cnt_q == '0) begin
      eff_cnt = mash_pkg::BUCKET_CNT_W'(1);
    end else if (bucket_cnt_q > mash_pkg::BUCKET_CNT_W'(mash_pkg::MAX_BUCKETS)) begin
      eff_cnt = mash_pkg::BUCKET_CNT_W'(mash_pkg::MAX_BUCKETS);
    end else begin
      eff_cnt = bucket_cnt_q;
    end
  end

  // restoring remainder step, one dividend bit per cycle
  assign div_shift   = {div_rem_q, div_num_q[mash_pkg::HASH_W-1]};
  assign div_den_ext = {1'b0, div_den_q};
  assign div_sub     = div_shift - div_den_ext;
  assign rem_next    = (div_shift >= div_den_ext) ? div_sub[mash_pkg::BUCKET_CNT_W-1:0]
                                                  : div_shift[mash_pkg::BUCKET_CNT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_num_q <= hash_d;
      div_rem_q <= '0;
      div_den_q <= eff_cnt;
    end else if (cmd_i.div_step) begin
      div_num_q <= div_num_q << 1;
      div_rem_q <= rem_next;
    end
  end

  // result register; the running hash is frozen while dividing
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hash_q   <= hash_q;
      out_bucket_q <= div_rem_q[mash_pkg::BUCKET_IDX_W-1:0];
    end
  end

  assign hash_value_o   = out_hash_q;
  assign bucket_index_o = out_bucket_q;

endmodule
